@@ hdl/assert_macros.svh @@
// assertion macros used by the checksum engine
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every clock edge out of reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// condition must never be seen out of reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

@@ hdl/tmce_pkg.sv @@
// shared types and constants for the tile map checksum engine
`timescale 1ns / 1ps
package tmce_pkg;
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CHECK = 2'd2;
  localparam logic [1:0] CMD_SEED  = 2'd3;

  localparam logic [7:0] DOOR_FIRST = 8'hA2;
  localparam logic [7:0] DOOR_LAST  = 8'hA9;
  localparam logic [7:0] DOOR_OPEN  = 8'hAA;
  localparam logic [7:0] CSUM_LAST  = 8'hA0;
  localparam int ROW_STEP = 32;
  localparam int COL_STEP = 31;
  localparam logic [7:0] ROW_STEP_B = 8'd32;
  localparam logic [7:0] COL_STEP_B = 8'd31;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_CLEAR = 7'b0000010,
    ST_RDW   = 7'b0000100,
    ST_CSUM  = 7'b0001000,
    ST_CACC  = 7'b0010000,
    ST_SEED  = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_t;

  function automatic logic solid_of(input logic [7:0] t);
    logic s;
    s = 1'b0;
    if (t == 8'd0) s = 1'b0;
    else if (t >= DOOR_FIRST && t <= DOOR_LAST) s = 1'b0;
    else if (t < DOOR_OPEN) s = 1'b1;
    else if (t >= 8'd192 && t <= 8'd240) s = 1'b1;
    else if (t >= 8'd242 && t <= 8'd252) s = 1'b1;
    return s;
  endfunction
endpackage

@@ hdl/tmce_grid_mem.sv @@
// tile grid memory, one write and one registered read port
`timescale 1ns / 1ps
module tmce_grid_mem #(
  parameter int AW = 20
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);
  logic [7:0] mem [2**AW];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

@@ hdl/tmce_door_mem.sv @@
// door list memory: col, row and door id offset per entry
`timescale 1ns / 1ps
module tmce_door_mem #(
  parameter int AW = 8,
  parameter int DW = 23
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);
  logic [DW-1:0] mem [2**AW];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

@@ hdl/tile_map_checksum_engine.sv @@
// Tile map checksum engine: a MAP_SIDE x MAP_SIDE byte grid in one
// synchronous memory and a door list in a second one. After reset the grid
// memory is cleared one cell a cycle, while no command is accepted. A
// checksum reads each sampled cell through the grid port in the CSUM and
// CACC states; sampled positions outside the grid, as from a negative start
// row or column, are stepped through but not counted. Seed doors reads the
// listed doors one after another and writes each one into the grid. One
// command is worked at a time; the result waits in an output register.
`timescale 1ns / 1ps
module tile_map_checksum_engine
  import tmce_pkg::*;
#(
  parameter int MAP_SIDE  = 1024,
  parameter int MAX_DOORS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // command[1:0], col[11:2], row[21:12], tile_value[29:22], check_key[61:30],
  // door_seed[69:62], zero pad
  input  logic [71:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // read_tile[7:0], read_solid[8], checksum_value[40:9], door_list_full[41], pad
  output logic [47:0] out_tdata,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);
`include "assert_macros.svh"
  localparam int CW  = $clog2(MAP_SIDE);
  localparam int GAW = 2 * CW;
  localparam int DAW = (MAX_DOORS > 1) ? $clog2(MAX_DOORS) : 1;
  localparam int DCW = $clog2(MAX_DOORS + 1);
  localparam int DEW = 2 * CW + 3;
  localparam logic [GAW:0] GRID_CELLS = (GAW+1)'(2**GAW);
  localparam logic [10:0] SIDE11 = 11'(MAP_SIDE);
  // start marker, no row position ever reaches it
  localparam logic [10:0] ROW_START = 11'h600;

  logic [1:0]  f_cmd;
  logic [9:0]  f_col, f_row;
  logic [7:0]  f_tv, f_seed;
  logic [31:0] f_key;
  assign f_cmd  = in_tdata[1:0];
  assign f_col  = in_tdata[11:2];
  assign f_row  = in_tdata[21:12];
  assign f_tv   = in_tdata[29:22];
  assign f_key  = in_tdata[61:30];
  assign f_seed = in_tdata[69:62];

  state_t state_r, state_nxt;
  logic [7:0]  safe_r;
  logic [GAW:0] clr_r;
  logic [DCW-1:0] dtot_r;
  logic [DCW-1:0] di_r;
  logic [1:0]  cmd_r;
  logic [9:0]  col_r, row_r;
  logic [7:0]  tv_r, seed_r;
  logic [31:0] key_r, acc_r;
  logic [10:0] cr_r, cc_r, c0_r;
  logic        cvalid_r;
  logic [7:0]  o_tile_r;
  logic        o_solid_r, o_full_r;
  logic [31:0] o_sum_r;
  logic        out_v_r;

  logic          g_we;
  logic [GAW-1:0] g_wa, g_ra;
  logic [7:0]    g_wd, g_rd;
  logic          d_we;
  logic [DEW-1:0] d_wd, d_rd;
  logic [DAW-1:0] d_wa, d_ra;

  tmce_grid_mem #(.AW(GAW)) u_grid (
    .clk(clk), .we(g_we), .waddr(g_wa), .wdata(g_wd), .raddr(g_ra), .rdata(g_rd)
  );
  tmce_door_mem #(.AW(DAW), .DW(DEW)) u_door (
    .clk(clk), .we(d_we), .waddr(d_wa), .wdata(d_wd), .raddr(d_ra), .rdata(d_rd)
  );

  logic accept;
  assign in_tready = (state_r == ST_IDLE) && !out_v_r;
  assign accept    = in_tvalid && in_tready;

  // truncating remainders of the signed key
  logic [31:0] mag;
  logic [4:0]  m32;
  logic [4:0]  m31;
  logic [10:0] r0, cst;
  logic        kneg;
  logic [31:0] mag_k;
  logic [7:0]  s31_a;
  logic [5:0]  s31_b;
  logic [4:0]  s31_c;
  always_comb begin
    kneg  = key_r[31];
    mag_k = kneg ? (~key_r + 32'd1) : key_r;
    mag   = mag_k;
    m32   = mag[4:0];
    // 32 is 1 mod 31, so summing 5-bit digits keeps the remainder
    s31_a = 8'(mag[4:0]) + 8'(mag[9:5]) + 8'(mag[14:10]) + 8'(mag[19:15]) +
            8'(mag[24:20]) + 8'(mag[29:25]) + 8'(mag[31:30]);
    s31_b = 6'(s31_a[7:5]) + 6'(s31_a[4:0]);
    s31_c = 5'(s31_b[5]) + s31_b[4:0];
    m31   = (s31_c == 5'd31) ? 5'd0 : s31_c;
    r0    = kneg ? (11'd0 - 11'(m32)) : 11'(m32);
    cst   = kneg ? (11'd0 - 11'(m31)) : 11'(m31);
  end

  logic in_side_r, in_side_c, row_neg, row_done;
  assign in_side_r = !cr_r[10] && (cr_r < SIDE11);
  assign in_side_c = !cc_r[10] && (cc_r < SIDE11);
  // negative rows sit at the top of the 11-bit range, past rows stay below 0x600
  assign row_neg   = cr_r[10] && cr_r[9];
  assign row_done  = !row_neg && !in_side_r;

  logic [CW-1:0] dcol, drow;
  logic [2:0]    dslot;
  assign dcol  = d_rd[CW-1:0];
  assign drow  = d_rd[2*CW-1:CW];
  assign dslot = d_rd[DEW-1:2*CW];
  logic is_door;
  assign is_door = (tv_r >= DOOR_FIRST) && (tv_r <= DOOR_LAST);
  logic cell_ok;
  assign cell_ok = (32'(col_r) < 32'(MAP_SIDE)) && (32'(row_r) < 32'(MAP_SIDE));

  always_comb begin
    state_nxt = state_r;
    g_we = 1'b0; g_wa = '0; g_wd = '0; g_ra = '0;
    d_we = 1'b0;
    d_wa = DAW'(dtot_r);
    d_wd = {3'(tv_r - DOOR_FIRST), row_r[CW-1:0], col_r[CW-1:0]};
    d_ra = DAW'(di_r);
    unique case (state_r)
      ST_CLEAR: begin
        g_we = 1'b1; g_wa = clr_r[GAW-1:0];
        if (clr_r == GRID_CELLS - 1'b1) state_nxt = ST_IDLE;
      end
      ST_IDLE: if (accept) begin
        unique case (f_cmd)
          CMD_CHECK: state_nxt = ST_CSUM;
          CMD_SEED:  state_nxt = ST_SEED;
          default:   state_nxt = ST_RDW;
        endcase
      end
      ST_RDW: begin
        g_ra = {row_r[CW-1:0], col_r[CW-1:0]};
        if (cmd_r == CMD_WRITE && cell_ok) begin
          g_we = 1'b1; g_wa = {row_r[CW-1:0], col_r[CW-1:0]}; g_wd = tv_r;
          d_we = is_door && (32'(dtot_r) < 32'(MAX_DOORS));
        end
        state_nxt = ST_OUT;
      end
      ST_CSUM: begin
        g_ra = {cr_r[CW-1:0], cc_r[CW-1:0]};
        if (cr_r == ROW_START) state_nxt = ST_CSUM;
        else if (row_done) state_nxt = ST_OUT;
        else state_nxt = ST_CACC;
      end
      ST_CACC: state_nxt = ST_CSUM;
      ST_SEED: begin
        if (cvalid_r && (32'(drow) < 32'(MAP_SIDE)) && (32'(dcol) < 32'(MAP_SIDE))) begin
          g_we = 1'b1; g_wa = {drow, dcol};
          g_wd = seed_r[dslot] ? (DOOR_FIRST + 8'(dslot)) : DOOR_OPEN;
        end
        if (di_r >= dtot_r && !cvalid_r) state_nxt = ST_OUT;
      end
      ST_OUT: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  logic [7:0] t_rd;
  assign t_rd = g_rd;
  logic counts;
  assign counts = (t_rd >= 8'd1 && t_rd <= CSUM_LAST) || (t_rd == safe_r);
  logic read_ok;
  assign read_ok = cell_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
      safe_r  <= 8'd171;
      dtot_r  <= '0;
      out_v_r <= 1'b0;
      cvalid_r <= 1'b0;
      di_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) safe_r <= cfg_wr_data;
      if (out_v_r && out_tready) out_v_r <= 1'b0;
      unique case (state_r)
        ST_CLEAR: clr_r <= clr_r + 1'b1;
        ST_IDLE: if (accept) begin
          cmd_r <= f_cmd; col_r <= f_col; row_r <= f_row;
          tv_r <= f_tv; key_r <= f_key; seed_r <= f_seed;
          acc_r <= f_key;
          di_r <= '0; cvalid_r <= 1'b0;
          o_tile_r <= '0; o_solid_r <= 1'b0; o_sum_r <= '0; o_full_r <= 1'b0;
          cr_r <= ROW_START;
        end
        ST_RDW: begin
          if (g_we && d_we) dtot_r <= dtot_r + 1'b1;
          o_full_r <= (cmd_r == CMD_WRITE) && cell_ok && is_door &&
                      !(32'(dtot_r) < 32'(MAX_DOORS));
        end
        ST_CSUM: begin
          // first entry sets the start row and column
          if (cr_r == ROW_START) begin
            cr_r <= r0; cc_r <= cst; c0_r <= cst;
          end else begin
            cvalid_r <= in_side_r && in_side_c;
          end
        end
        ST_CACC: begin
          if (cvalid_r && counts) acc_r <= acc_r + (key_r ^ 32'(t_rd));
          cvalid_r <= 1'b0;
          if (32'(cc_r + 11'(COL_STEP_B)) >= 32'(MAP_SIDE) && !cc_r[10]) begin
            cc_r <= c0_r; cr_r <= cr_r + 11'(ROW_STEP_B);
          end else begin
            cc_r <= cc_r + 11'(COL_STEP_B);
          end
        end
        ST_SEED: begin
          cvalid_r <= (di_r < dtot_r);
          if (di_r < dtot_r) di_r <= di_r + 1'b1;
        end
        ST_OUT: begin
          out_v_r <= 1'b1;
          if (cmd_r == CMD_READ) begin
            o_tile_r  <= read_ok ? t_rd : 8'd0;
            o_solid_r <= read_ok ? solid_of(t_rd) : 1'b0;
          end
          if (cmd_r == CMD_CHECK) o_sum_r <= acc_r;
        end
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {6'd0, o_full_r, o_sum_r, o_solid_r, o_tile_r};

  `ASSERT_CLK(a_no_accept_busy, clk, rst_n, (state_r != ST_IDLE) |-> !in_tready)
  `ASSERT_NEVER(a_doors_bounded, clk, rst_n, 32'(dtot_r) > 32'(MAX_DOORS))
  `ASSERT_CLK(a_out_from_out, clk, rst_n, $rose(out_v_r) |-> $past(state_r == ST_OUT))
endmodule
